@@ src/bbqc_pkg.sv @@
// Shared types and constants for the blocked-board queens counter.
// No dependencies; imported by bbqc_cell, blocked_board_queens_counter and the testbench.
package bbqc_pkg;

    localparam int BOARD_SIZE_DEFAULT = 8;
    localparam int ROW_STRIDE         = 8;   // bits per row in the input mask
    localparam int MASK_W             = 64;
    localparam int COUNT_W            = 7;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic load;   // latch masks from the row above and build the free set
        logic take;   // consume the lowest free column of this row
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FLUSH
    } state_t;

endpackage

@@ src/blocked_board_queens_counter.sv @@
// Blocked-board queens counter, top level: sequencer, row-cell chain and
// output register. Depends on bbqc_pkg and bbqc_cell.
//
// Each board is a 64-bit mask of blocked squares (bit r*8+c); the block
// returns the number of ways to place BOARD_SIZE non-attacking queens on free
// squares of the top-left BOARD_SIZE x BOARD_SIZE corner. The search is a
// depth-first walk over a chain of row cells, one search node per clock: each
// cycle the active row either tries its next free column (moving one row down,
// or counting a solution on the last row) or, when it has none left, steps
// back one row. The search ends when the first row has no free column left; an
// open 8x8 board tries 2056 columns and steps back 1965 times, counting that
// exhausted first row as the last backtrack. The next board is accepted as
// soon as the count has moved to the output register, even if it is not yet
// taken.
module blocked_board_queens_counter import bbqc_pkg::*; #(
    parameter int BOARD_SIZE = BOARD_SIZE_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MASK_W-1:0]  s_blocked_squares,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_solution_count
);

    localparam int IDX_W = (BOARD_SIZE > 1) ? $clog2(BOARD_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(BOARD_SIZE - 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   active_reg, active_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] result_reg;
    logic               m_valid_reg;
    logic [MASK_W-1:0]  blocked_reg;
    logic [MASK_W-1:0]  board_bits;

    logic s_xfer, out_free, search_step, search_end, result_load, cur_avail;

    logic [BOARD_SIZE-1:0] has_avail;
    logic [BOARD_SIZE-1:0] load_vec;
    cell_ctrl_t            ctrl   [BOARD_SIZE];
    logic [BOARD_SIZE-1:0] cols_link   [BOARD_SIZE+1];
    logic [BOARD_SIZE-1:0] diag_l_link [BOARD_SIZE+1];
    logic [BOARD_SIZE-1:0] diag_r_link [BOARD_SIZE+1];

    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cur_avail = has_avail[active_reg];
    assign search_end = !cur_avail && (active_reg == '0);

    // row 0 loads during the transfer, before blocked_reg holds the new board
    assign board_bits = s_xfer ? s_blocked_squares : blocked_reg;

    // first row starts with nothing attacked
    assign cols_link[0]   = '0;
    assign diag_l_link[0] = '0;
    assign diag_r_link[0] = '0;

    for (genvar r = 0; r < BOARD_SIZE; r++) begin : g_row
        logic [BOARD_SIZE-1:0] row_free;

        assign row_free = ~board_bits[r*ROW_STRIDE +: BOARD_SIZE];

        always_comb begin
            if (r == 0) begin
                ctrl[r].load = s_xfer;
            end else begin
                ctrl[r].load = search_step && cur_avail && (active_reg == IDX_W'(r - 1));
            end
            ctrl[r].take = search_step && cur_avail && (active_reg == IDX_W'(r));
        end
        assign load_vec[r] = ctrl[r].load;

        bbqc_cell #(.BOARD_SIZE(BOARD_SIZE)) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl[r]),
            .row_free   (row_free),
            .cols_in    (cols_link[r]),
            .diag_l_in  (diag_l_link[r]),
            .diag_r_in  (diag_r_link[r]),
            .cols_out   (cols_link[r+1]),
            .diag_l_out (diag_l_link[r+1]),
            .diag_r_out (diag_r_link[r+1]),
            .has_avail  (has_avail[r])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (search_end) state_next = out_free ? ST_IDLE : ST_FLUSH;
            end
            ST_FLUSH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready     = 1'b0;
        search_step = 1'b0;
        result_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SEARCH: begin
                search_step = 1'b1;
                result_load = search_end && out_free;
            end
            ST_FLUSH: begin
                result_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // row pointer and solution count
    always_comb begin
        active_next = active_reg;
        count_next  = count_reg;
        if (s_xfer) begin
            active_next = '0;
            count_next  = '0;
        end else if (search_step) begin
            if (cur_avail) begin
                if (active_reg == LAST_ROW) begin
                    count_next = count_reg + COUNT_W'(1);
                end else begin
                    active_next = active_reg + IDX_W'(1);
                end
            end else if (active_reg != '0) begin
                active_next = active_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            active_reg  <= '0;
            count_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) blocked_reg <= s_blocked_squares;
        if (result_load) result_reg <= count_reg;
    end

    assign m_valid          = m_valid_reg;
    assign m_solution_count = result_reg;

    // at most one row latches new masks per cycle
    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(load_vec))
        else $error("more than one row cell loaded");

    // the row pointer stays on the board
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        search_step |-> (active_reg <= LAST_ROW))
        else $error("row pointer off the board");

    // a transfer in starts a fresh search at the first row
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == ST_SEARCH) && (active_reg == '0) && (count_reg == '0))
        else $error("search did not start at row zero");

    // a result is never overwritten while still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !result_load)
        else $error("pending result overwritten");

endmodule

@@ src/bbqc_cell.sv @@
// One row cell of the queens search chain: holds the attack masks and the
// remaining candidate columns of its row. Depends on bbqc_pkg.
module bbqc_cell import bbqc_pkg::*; #(
    parameter int BOARD_SIZE = BOARD_SIZE_DEFAULT
) (
    input  logic                  aclk,
    input  cell_ctrl_t            ctrl,
    input  logic [BOARD_SIZE-1:0] row_free,
    input  logic [BOARD_SIZE-1:0] cols_in,
    input  logic [BOARD_SIZE-1:0] diag_l_in,
    input  logic [BOARD_SIZE-1:0] diag_r_in,
    output logic [BOARD_SIZE-1:0] cols_out,
    output logic [BOARD_SIZE-1:0] diag_l_out,
    output logic [BOARD_SIZE-1:0] diag_r_out,
    output logic                  has_avail
);

    logic [BOARD_SIZE-1:0] cols_reg, diag_l_reg, diag_r_reg, avail_reg;
    logic [BOARD_SIZE-1:0] avail_next, pick;

    // lowest set bit of the candidate set
    assign pick      = avail_reg & (~avail_reg + BOARD_SIZE'(1));
    assign has_avail = |avail_reg;

    always_comb begin
        avail_next = avail_reg;
        if (ctrl.load) begin
            avail_next = row_free & ~(cols_in | diag_l_in | diag_r_in);
        end else if (ctrl.take) begin
            avail_next = avail_reg & ~pick;
        end
    end

    always_ff @(posedge aclk) begin
        avail_reg <= avail_next;
        if (ctrl.load) begin
            cols_reg   <= cols_in;
            diag_l_reg <= diag_l_in;
            diag_r_reg <= diag_r_in;
        end
    end

    // masks seen by the next row if the picked column is kept;
    // the left shift drops bits past the board edge
    assign cols_out   = cols_reg | pick;
    assign diag_l_out = (diag_l_reg | pick) << 1;
    assign diag_r_out = (diag_r_reg | pick) >> 1;

endmodule

@@ tb/blocked_board_queens_counter_tb.sv @@
// Self-checking testbench for blocked_board_queens_counter: directed boards, then random boards
// under several handshake idling mixes; unlisted counts come from a local backtracking search.
// Depends on bbqc_pkg and the blocked_board_queens_counter RTL.
`timescale 1ns / 100ps

module blocked_board_queens_counter_tb;
    import bbqc_pkg::*;

    localparam int BSIZE          = BOARD_SIZE_DEFAULT;
    localparam logic [7:0] FULL   = 8'((1 << BSIZE) - 1);
    localparam int RANDOM_PER_PHASE = 65;
    localparam int TAIL_CYCLES    = 4400;   // one open-board search plus margin
    localparam int HOLD_CYCLES    = 10000;  // longer than two searches, so the block fills
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [MASK_W-1:0]  mask;
        bit                 known;
        logic [COUNT_W-1:0] count;
    } board_case_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [MASK_W-1:0]  s_blocked_squares = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [COUNT_W-1:0] m_solution_count;

    logic [COUNT_W-1:0] pending_counts[$];
    board_case_t        dir_cases[$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    bit                 hold_request = 1'b0;

    always #6 aclk = ~aclk;

    blocked_board_queens_counter #(.BOARD_SIZE(BSIZE)) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_blocked_squares (s_blocked_squares),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_solution_count  (m_solution_count)
    );

    // Row-by-row backtracking over free squares; columns and both diagonals tracked.
    function automatic int unsigned placements_from(input logic [63:0] blocked, input int row,
                                                    input logic [7:0] cols,
                                                    input logic [7:0] diag_l,
                                                    input logic [7:0] diag_r);
        logic [7:0]  avail;
        logic [7:0]  pick;
        int unsigned total;
        if (row >= BSIZE)
            return 1;
        total = 0;
        avail = FULL & ~blocked[row*ROW_STRIDE +: 8] & ~(cols | diag_l | diag_r);
        while (avail != 8'd0) begin
            pick  = avail & (~avail + 8'd1);
            avail = avail & ~pick;
            total += placements_from(blocked, row + 1, cols | pick,
                                     ((diag_l | pick) << 1) & FULL, (diag_r | pick) >> 1);
        end
        return total;
    endfunction

    function automatic logic [COUNT_W-1:0] queens_count(input logic [63:0] blocked);
        int unsigned n;
        n = placements_from(blocked, 0, 8'd0, 8'd0, 8'd0);
        return n[COUNT_W-1:0];
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mask with exactly one legal placement's squares set, found by permutation trials.
    function automatic logic [63:0] random_solution_squares();
        int  col[8];
        int  j;
        int  tmp;
        bit  ok;
        logic [63:0] sq;
        do begin
            for (int r = 0; r < 8; r++) col[r] = r;
            for (int r = 7; r > 0; r--) begin
                j = $urandom_range(r);
                tmp = col[r]; col[r] = col[j]; col[j] = tmp;
            end
            ok = 1'b1;
            for (int a = 0; a < BSIZE; a++)
                for (int b = a + 1; b < BSIZE; b++)
                    if (col[a] - col[b] == a - b || col[a] - col[b] == b - a)
                        ok = 1'b0;
        end while (!ok);
        sq = '0;
        for (int r = 0; r < BSIZE; r++) sq[r*ROW_STRIDE + col[r]] = 1'b1;
        return sq;
    endfunction

    function automatic logic [63:0] random_board();
        int          kind;
        int          density;
        logic [63:0] m;
        kind = $urandom_range(99);
        if (kind < 40) begin
            // board that keeps at least one placement open
            density = $urandom_range(1, 3);
            m = rand_word();
            for (int k = 1; k < density; k++) m = m & rand_word();
            m = m & ~random_solution_squares();
        end else if (kind < 65) begin
            density = $urandom_range(2, 4);
            m = rand_word();
            for (int k = 1; k < density; k++) m = m & rand_word();
        end else if (kind < 80) begin
            m = rand_word();
        end else if (kind < 90) begin
            m = '0;
            repeat ($urandom_range(1, 3)) m[$urandom_range(63)] = 1'b1;
        end else begin
            m = rand_word() & rand_word() & rand_word();
            m[$urandom_range(BSIZE - 1)*ROW_STRIDE +: 8] = 8'hFF;
        end
        return m;
    endfunction

    // One transfer on the input channel; valid stays high across back-to-back boards.
    task automatic send_board(input logic [63:0] mask, input bit known,
                              input logic [COUNT_W-1:0] count);
        if (send_idle_pct > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid           <= 1'b1;
        s_blocked_squares <= mask;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_counts.insert(pending_counts.size(), known ? count : queens_count(mask));
    endtask

    task automatic drain_results();
        while (pending_counts.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls per phase, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result check and watchdog
    always @(posedge aclk) begin
        logic [COUNT_W-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_counts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: solution_count=%0d", m_solution_count);
                end else begin
                    want = pending_counts.pop_front();
                    if (m_solution_count !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("solution_count mismatch: expected %0d, got %0d",
                                     want, m_solution_count);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("** blocked_board_queens_counter: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] one_sol;
        one_sol = (64'd1 << 0) | (64'd1 << 12) | (64'd1 << 23) | (64'd1 << 29)
                | (64'd1 << 34) | (64'd1 << 46) | (64'd1 << 49) | (64'd1 << 59);

        dir_cases.insert(dir_cases.size(), '{64'h0000_0000_0000_0000, 1'b1, 7'd92}); // open
        dir_cases.insert(dir_cases.size(), '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'h0000_0000_0000_00FF, 1'b1, 7'd0}); // top row
        dir_cases.insert(dir_cases.size(), '{64'hFF00_0000_0000_0000, 1'b1, 7'd0}); // bottom row
        dir_cases.insert(dir_cases.size(), '{64'h0000_00FF_0000_0000, 1'b1, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'h0101_0101_0101_0101, 1'b1, 7'd0}); // column 0
        dir_cases.insert(dir_cases.size(), '{64'h8080_8080_8080_8080, 1'b1, 7'd0}); // column 7
        dir_cases.insert(dir_cases.size(), '{64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'hF0F0_F0F0_F0F0_F0F0, 1'b1, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'hFFFF_FFFF_0000_0000, 1'b1, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'h8040_2010_0804_0201, 1'b0, 7'd0}); // main diag
        dir_cases.insert(dir_cases.size(), '{64'h0102_0408_1020_4080, 1'b0, 7'd0}); // anti-diag
        dir_cases.insert(dir_cases.size(), '{64'hAA55_AA55_AA55_AA55, 1'b0, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'h55AA_55AA_55AA_55AA, 1'b0, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'h0000_0000_0000_0001, 1'b0, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'h8000_0000_0000_0000, 1'b0, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'h8000_0000_0000_0001, 1'b0, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'h0000_0000_0000_00FE, 1'b0, 7'd0}); // one corner
        dir_cases.insert(dir_cases.size(), '{64'h7F00_0000_0000_0000, 1'b0, 7'd0});
        dir_cases.insert(dir_cases.size(), '{64'h0000_0018_1800_0000, 1'b0, 7'd0}); // center
        dir_cases.insert(dir_cases.size(), '{64'h0123_4567_89AB_CDEF, 1'b0, 7'd0});
        dir_cases.insert(dir_cases.size(), '{~one_sol, 1'b0, 7'd0}); // single placement left
        dir_cases.insert(dir_cases.size(), '{one_sol, 1'b0, 7'd0});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_cases[i])
            send_board(dir_cases[i].mask, dir_cases[i].known, dir_cases[i].count);
        s_valid <= 1'b0;
        @(posedge aclk);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // long receiver hold-off while boards keep coming
                if (phase == 0 && n == 20)
                    hold_request = 1'b1;
                send_board(random_board(), 1'b0, '0);
            end
            // sender pauses until all results are back
            s_valid <= 1'b0;
            @(posedge aclk);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_counts.size() == 0) begin
            $display("** blocked_board_queens_counter: PASSED **");
        end else begin
            $display("** blocked_board_queens_counter: FAILED **");
        end
        $finish;
    end

endmodule

@@ blocked_board_queens_counter.f @@
src/bbqc_pkg.sv
src/bbqc_cell.sv
src/blocked_board_queens_counter.sv
tb/blocked_board_queens_counter_tb.sv
